// ===== hw/rtl/hbe_pkg.sv =====
// Shared types and constants of the histogram binning engine.
`default_nettype none
package hbe_pkg;
   localparam int MAX_BINS    = 1024;
   localparam int BIN_BITS    = $clog2(MAX_BINS);
   localparam int COUNT_BITS  = 32;
   localparam int SAMPLE_BITS = 32;
   localparam int NBINS_BITS  = 11;
   localparam int DB_BITS     = 16;
   localparam int QDEPTH      = 2;

   localparam logic [2:0] KIND_SAMPLE = 3'd0;
   localparam logic [2:0] KIND_CLEAR  = 3'd1;
   localparam logic [2:0] KIND_START  = 3'd2;
   localparam logic [2:0] KIND_STOP   = 3'd3;
   localparam logic [2:0] KIND_READ   = 3'd4;

   localparam logic [2:0] ST_COUNTED  = 3'd0;
   localparam logic [2:0] ST_RANGE    = 3'd1;
   localparam logic [2:0] ST_STOPPED  = 3'd2;
   localparam logic [2:0] ST_INVALID  = 3'd3;
   localparam logic [2:0] ST_DONE     = 3'd4;

   localparam logic [1:0] CSR_LOWER    = 2'd0;
   localparam logic [1:0] CSR_UPPER    = 2'd1;
   localparam logic [1:0] CSR_NBINS    = 2'd2;
   localparam logic [1:0] CSR_DEADBAND = 2'd3;

   localparam logic [1:0] OP_SAMPLE = 2'd0; // in range, needs divide
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3; // result already known, post check only if sample

   // classified word from front to back
   typedef struct packed {
      logic [1:0]            op;
      logic                  is_sample;
      logic [2:0]            status;
      logic [BIN_BITS-1:0]   rbin;
      logic [SAMPLE_BITS:0]  d;     // sample - lower
      logic [SAMPLE_BITS:0]  w;     // upper - lower
      logic [NBINS_BITS-1:0] n;     // effective bins
   } cmd_type;
endpackage
`default_nettype wire

// ===== hw/rtl/hbe_front.sv =====
// Front end: accepts words, checks limits and range, queues classified words.
`default_nettype none
module hbe_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [2:0]            req_kind,
   input  wire logic [31:0]           req_sample_value,
   input  wire logic [9:0]            req_read_bin,
   input  wire logic [31:0]           lower,
   input  wire logic [31:0]           upper,
   input  wire logic [hbe_pkg::NBINS_BITS-1:0] nbins,
   output logic                       q_valid,
   input  wire logic                  q_ready,
   output hbe_pkg::cmd_type           q_cmd
);
   localparam int SB = hbe_pkg::SAMPLE_BITS;
   localparam int PB = $clog2(hbe_pkg::QDEPTH);
   hbe_pkg::cmd_type q_mem_ff [hbe_pkg::QDEPTH];
   logic [PB-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PB:0]   cnt_ff, cnt_in;
   logic          en_ff, en_in;
   hbe_pkg::cmd_type c;
   logic signed [SB:0] s, lo, hi;
   logic push, pop;

   assign req_ready = (cnt_ff != (PB+1)'(hbe_pkg::QDEPTH));
   assign push = req_valid && req_ready;
   assign q_valid = (cnt_ff != '0);
   assign pop = q_valid && q_ready;
   assign q_cmd = q_mem_ff[rp_ff];

   always_comb begin
      s  = {req_sample_value[SB-1], req_sample_value[SB-1:0]};
      lo = {lower[31], lower};
      hi = {upper[31], upper};
      c = '0;
      c.rbin = req_read_bin;
      c.d = s - lo;
      c.w = hi - lo;
      c.n = (nbins == '0) ? hbe_pkg::NBINS_BITS'(1) :
            (nbins > hbe_pkg::NBINS_BITS'(hbe_pkg::MAX_BINS)) ?
            hbe_pkg::NBINS_BITS'(hbe_pkg::MAX_BINS) : nbins;
      c.op = hbe_pkg::OP_NONE;
      c.status = hbe_pkg::ST_DONE;
      en_in = en_ff;
      unique case (req_kind)
         hbe_pkg::KIND_SAMPLE: begin
            c.is_sample = 1'b1;
            priority if (!en_ff) c.status = hbe_pkg::ST_STOPPED;
            else if (lo >= hi) c.status = hbe_pkg::ST_INVALID;
            else if (s < lo || s >= hi) c.status = hbe_pkg::ST_RANGE;
            else begin
               c.status = hbe_pkg::ST_COUNTED;
               c.op = hbe_pkg::OP_SAMPLE;
            end
         end
         hbe_pkg::KIND_CLEAR: c.op = hbe_pkg::OP_CLEAR;
         hbe_pkg::KIND_START: en_in = 1'b1;
         hbe_pkg::KIND_STOP:  en_in = 1'b0;
         hbe_pkg::KIND_READ:  c.op = hbe_pkg::OP_READ;
         default: ;
      endcase
      if (!push) en_in = en_ff;
      wp_in = push ? wp_ff + PB'(1) : wp_ff;
      rp_in = pop ? rp_ff + PB'(1) : rp_ff;
      cnt_in = cnt_ff + (PB+1)'(push) - (PB+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) q_mem_ff[wp_ff] <= c;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; en_ff <= 1'b1;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in; en_ff <= en_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/hbe_back.sv =====
// Back end: divider, bin memory with clearing sweep, post logic, output register.
`default_nettype none
module hbe_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   output logic                       q_ready,
   input  wire hbe_pkg::cmd_type      q_cmd,
   input  wire logic [hbe_pkg::DB_BITS-1:0] deadband,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [2:0]                 rsp_status,
   output logic [9:0]                 rsp_bin_index,
   output logic [31:0]                rsp_bin_value,
   output logic                       rsp_post_value
);
   localparam int BB = hbe_pkg::BIN_BITS;
   localparam int CB = hbe_pkg::COUNT_BITS;
   localparam int DW = hbe_pkg::SAMPLE_BITS + hbe_pkg::NBINS_BITS + 1; // dividend width
   localparam int WW = hbe_pkg::SAMPLE_BITS + 1;
   localparam int IB = $clog2(DW + 1);

   localparam logic [2:0] S_INIT = 3'd0, S_IDLE = 3'd1, S_DIV = 3'd2,
                          S_RD = 3'd3, S_WR = 3'd4, S_OUT = 3'd5, S_CLR = 3'd6;

   logic [CB-1:0] mem [hbe_pkg::MAX_BINS];
   logic [CB-1:0] rdata_ff;
   logic [2:0] st_ff, st_in;
   hbe_pkg::cmd_type cmd_ff, cmd_in;
   logic [DW-1:0] num_ff, num_in;   // dividend shifts out, quotient shifts in
   logic [WW-1:0] rem_ff, rem_in;
   logic [IB-1:0] it_ff, it_in;
   logic [BB:0]   clr_ff, clr_in;
   logic [BB-1:0] addr;
   logic [31:0]   csp_ff, csp_in;
   logic          ov_ff, ov_in;
   logic [2:0] o_st_ff, o_st_in;
   logic [BB-1:0] o_idx_ff, o_idx_in;
   logic [CB-1:0] o_val_ff, o_val_in;
   logic o_post_ff, o_post_in;
   logic we;
   logic [CB-1:0] wdata;
   logic [WW:0] trial;
   logic [DW-1:0] q_full;
   logic [BB-1:0] bin;
   logic [31:0] csp_t;

   assign q_ready = (st_ff == S_IDLE) && !ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_status = o_st_ff;
   assign rsp_bin_index = o_idx_ff;
   assign rsp_bin_value = o_val_ff;
   assign rsp_post_value = o_post_ff;

   always_comb begin
      // ceil(d*n/w): divide d*n + w - 1 by w
      trial = {rem_ff, num_ff[DW-1]} - {1'b0, cmd_ff.w};
      q_full = num_ff;
      bin = (q_full <= DW'(1)) ? '0 : BB'(q_full - DW'(1));
      if (DW'(bin) >= DW'(cmd_ff.n) - DW'(1)) bin = BB'(cmd_ff.n - hbe_pkg::NBINS_BITS'(1));
      if (q_full > DW'(cmd_ff.n)) bin = BB'(cmd_ff.n - hbe_pkg::NBINS_BITS'(1));
      st_in = st_ff; cmd_in = cmd_ff; num_in = num_ff; rem_in = rem_ff; it_in = it_ff;
      clr_in = clr_ff; csp_in = csp_ff; ov_in = ov_ff;
      o_st_in = o_st_ff; o_idx_in = o_idx_ff; o_val_in = o_val_ff; o_post_in = o_post_ff;
      we = 1'b0; wdata = '0; addr = cmd_ff.rbin;
      csp_t = csp_ff;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (st_ff)
         S_INIT, S_CLR: begin
            we = 1'b1; addr = clr_ff[BB-1:0];
            clr_in = clr_ff + (BB+1)'(1);
            if (clr_ff == (BB+1)'(hbe_pkg::MAX_BINS - 1)) begin
               st_in = (st_ff == S_INIT) ? S_IDLE : S_OUT;
               clr_in = '0;
            end
         end
         S_IDLE: if (q_valid && !ov_ff) begin
            cmd_in = q_cmd;
            unique case (q_cmd.op)
               hbe_pkg::OP_SAMPLE: begin
                  st_in = S_DIV; it_in = '0; rem_in = '0;
                  num_in = DW'(q_cmd.d) * DW'(q_cmd.n) + DW'(q_cmd.w) - DW'(1);
               end
               hbe_pkg::OP_CLEAR: begin
                  st_in = S_CLR; clr_in = '0;
                  csp_in = 32'(deadband) + 32'd1;
                  o_st_in = hbe_pkg::ST_DONE; o_idx_in = '0; o_val_in = '0; o_post_in = 1'b0;
               end
               hbe_pkg::OP_READ: st_in = S_RD;
               default: begin
                  o_st_in = q_cmd.status; o_idx_in = '0; o_val_in = '0; o_post_in = 1'b0;
                  if (q_cmd.is_sample && csp_ff > 32'(deadband)) begin
                     o_post_in = 1'b1; csp_in = '0;
                  end
                  ov_in = 1'b1;
               end
            endcase
         end
         S_DIV: begin
            if (!trial[WW]) begin
               rem_in = trial[WW-1:0]; num_in = {num_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[WW-2:0], num_ff[DW-1]}; num_in = {num_ff[DW-2:0], 1'b0};
            end
            it_in = it_ff + IB'(1);
            if (it_ff == IB'(DW - 1)) st_in = S_RD;
         end
         S_RD: begin
            if (cmd_ff.op == hbe_pkg::OP_SAMPLE) begin
               cmd_in.rbin = bin; st_in = S_WR;
            end else begin
               st_in = S_WR;
            end
         end
         S_WR: begin
            o_idx_in = cmd_ff.rbin; o_post_in = 1'b0; o_st_in = cmd_ff.status;
            if (cmd_ff.op == hbe_pkg::OP_SAMPLE) begin
               we = 1'b1;
               wdata = (rdata_ff == '1) ? CB'(1) : rdata_ff + CB'(1);
               o_val_in = wdata;
               if (csp_ff != '1) csp_t = csp_ff + 32'd1;
               csp_in = csp_t;
               if (csp_t > 32'(deadband)) begin
                  o_post_in = 1'b1; csp_in = '0;
               end
            end else o_val_in = rdata_ff;
            ov_in = 1'b1; st_in = S_IDLE;
         end
         S_OUT: begin
            ov_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[(st_ff == S_RD && cmd_ff.op == hbe_pkg::OP_SAMPLE) ? bin : cmd_ff.rbin];
      cmd_ff <= cmd_in; num_ff <= num_in; rem_ff <= rem_in; it_ff <= it_in;
      o_st_ff <= o_st_in; o_idx_ff <= o_idx_in; o_val_ff <= o_val_in; o_post_ff <= o_post_in;
      if (reset) begin
         st_ff <= S_INIT; clr_ff <= '0; csp_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; csp_ff <= csp_in; ov_ff <= ov_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/histogram_binning_engine.sv =====
// Top level of the histogram binning engine: CSRs, front end, queue, back end.
// Steps: in-range samples take the 44-step divider, a bin read and a write; reads take a
//   bin read and write; clear takes a one-bin-per-cycle sweep; others go straight out.
// Throughput: one word per back-end pass; no new word while a response is held.
// Reset: synchronous; registers return to lower 0, upper 0, bins 1; the back end then
//   zeroes all 1024 bins, while the front queue takes up to two words.
`default_nettype none
module histogram_binning_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic [31:0] req_sample_value,
   input  wire logic [9:0]  req_read_bin,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [9:0]       rsp_bin_index,
   output logic [31:0]      rsp_bin_value,
   output logic             rsp_post_value,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);
   logic [31:0] lower_ff, upper_ff;
   logic [hbe_pkg::NBINS_BITS-1:0] nbins_ff;
   logic [hbe_pkg::DB_BITS-1:0] db_ff;
   logic q_valid, q_ready;
   hbe_pkg::cmd_type q_cmd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0; upper_ff <= '0; nbins_ff <= hbe_pkg::NBINS_BITS'(1); db_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            hbe_pkg::CSR_LOWER:    lower_ff <= csr_write_data;
            hbe_pkg::CSR_UPPER:    upper_ff <= csr_write_data;
            hbe_pkg::CSR_NBINS:    nbins_ff <= csr_write_data[hbe_pkg::NBINS_BITS-1:0];
            hbe_pkg::CSR_DEADBAND: db_ff <= csr_write_data[hbe_pkg::DB_BITS-1:0];
            default: ;
         endcase
      end
   end

   // front classifies, queue decouples, back does the divide and bin update
   hbe_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_sample_value, .req_read_bin,
      .lower(lower_ff), .upper(upper_ff), .nbins(nbins_ff),
      .q_valid, .q_ready, .q_cmd
   );

   hbe_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_cmd, .deadband(db_ff),
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_bin_index, .rsp_bin_value, .rsp_post_value
   );
endmodule
`default_nettype wire
